@@ design/lpfd_pkg.sv @@
// Package with shared constants for the length-prefixed frame deframer.
`default_nettype none
package lpfd_pkg;

  localparam int unsigned LengthLimitDefault = 1024;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned LenOutW = 11;
  localparam int unsigned StatusW = 2;
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 32;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [LenOutW-1:0] LenOutMax = 11'd2047;

  localparam logic [StatusW-1:0] StOk      = 2'd0;
  localparam logic [StatusW-1:0] StVersion = 2'd1;
  localparam logic [StatusW-1:0] StTooLong = 2'd2;
  localparam logic [StatusW-1:0] StTerm    = 2'd3;

  localparam logic [CfgIdxW-1:0] RegExpectedVersion = 1'd0;
  localparam logic [CfgIdxW-1:0] RegEndMarker       = 1'd1;

  localparam logic [ByteW-1:0] ExpectedVersionReset = 8'd1;
  localparam logic [ByteW-1:0] EndMarkerReset       = 8'd0;

endpackage
`default_nettype wire

@@ design/length_prefixed_frame_deframer.sv @@
// Top level of the length-prefixed frame deframer with its output register.
`default_nettype none
// Parses a byte stream of frames made of a version byte, a type byte, a 16-bit
// big-endian payload length, the payload and a terminator byte. Every payload
// byte leaves as one transaction with the frame type and declared length; the
// terminator yields a closing transaction with tlast set and tuser giving the
// status. A wrong version byte or a declared length above LENGTH_LIMIT yields
// an error transaction at once and the search for a header restarts with the
// next byte. One byte is taken per clock cycle unless the input stalls: the
// parser state is updated in the cycle of the input transaction and the result
// is in the output register in the following cycle. The input stalls only while
// that output register holds a result that the downstream side does not take.
module length_prefixed_frame_deframer #(
  parameter int unsigned LENGTH_LIMIT = lpfd_pkg::LengthLimitDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [lpfd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [lpfd_pkg::ByteW-1:0]       cfg_data_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // Fields: rx_byte [7:0].
  input  wire logic [lpfd_pkg::InTdataW-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // Fields: frame_type [7:0], data_byte [15:8], payload_length [26:16], zero [31:27].
  output logic [lpfd_pkg::OutTdataW-1:0]        m_axis_tdata,
  // Fields: status [1:0].
  output logic [lpfd_pkg::StatusW-1:0]          m_axis_tuser,
  output logic                                  m_axis_tlast
);

  localparam int unsigned CntW = $clog2(LENGTH_LIMIT + 1);
  localparam int unsigned PadW = lpfd_pkg::OutTdataW - 2 * lpfd_pkg::ByteW
                                 - lpfd_pkg::LenOutW;

  typedef enum logic [2:0] {
    PhVersion = 3'd0,
    PhType    = 3'd1,
    PhLenHi   = 3'd2,
    PhLenLo   = 3'd3,
    PhPayload = 3'd4,
    PhTerm    = 3'd5
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic [lpfd_pkg::ByteW-1:0]    type_q, type_d;
  logic [lpfd_pkg::LenW-1:0]     len_q, len_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [CntW-1:0]               cnt_inc;
  logic [lpfd_pkg::ByteW-1:0]    exp_ver_q;
  logic [lpfd_pkg::ByteW-1:0]    end_mark_q;

  logic                          res_vld;
  logic [lpfd_pkg::ByteW-1:0]    res_type;
  logic [lpfd_pkg::ByteW-1:0]    res_data;
  logic [lpfd_pkg::LenW-1:0]     res_len;
  logic [lpfd_pkg::StatusW-1:0]  res_status;
  logic                          res_eof;
  logic [lpfd_pkg::LenW-1:0]     full_len;
  logic [lpfd_pkg::LenOutW-1:0]  res_len_sat;

  logic                          out_vld_q;
  logic [lpfd_pkg::ByteW-1:0]    out_type_q;
  logic [lpfd_pkg::ByteW-1:0]    out_data_q;
  logic [lpfd_pkg::LenOutW-1:0]  out_len_q;
  logic [lpfd_pkg::StatusW-1:0]  out_status_q;
  logic                          out_eof_q;

  logic                          in_acc;
  logic [lpfd_pkg::ByteW-1:0]    rx_byte;

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign rx_byte       = s_axis_tdata[lpfd_pkg::ByteW-1:0];
  assign cnt_inc       = cnt_q + CntW'(1);
  assign full_len      = {len_q[lpfd_pkg::LenW-1:lpfd_pkg::ByteW], rx_byte};

  always_comb begin
    phase_d    = phase_q;
    type_d     = type_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    res_vld    = 1'b0;
    res_type   = type_q;
    res_data   = '0;
    res_len    = len_q;
    res_status = lpfd_pkg::StOk;
    res_eof    = 1'b0;
    unique case (phase_q)
      PhType: begin
        type_d  = rx_byte;
        phase_d = PhLenHi;
      end
      PhLenHi: begin
        len_d   = {rx_byte, {lpfd_pkg::ByteW{1'b0}}};
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        len_d   = full_len;
        cnt_d   = '0;
        res_len = full_len;
        if (full_len > lpfd_pkg::LenW'(LENGTH_LIMIT)) begin
          phase_d    = PhVersion;
          res_vld    = 1'b1;
          res_status = lpfd_pkg::StTooLong;
          res_eof    = 1'b1;
        end else if (full_len == '0) begin
          phase_d = PhTerm;
        end else begin
          phase_d = PhPayload;
        end
      end
      PhPayload: begin
        cnt_d    = cnt_inc;
        res_vld  = 1'b1;
        res_data = rx_byte;
        if (lpfd_pkg::LenW'(cnt_inc) >= len_q) begin
          phase_d = PhTerm;
        end
      end
      PhTerm: begin
        phase_d    = PhVersion;
        cnt_d      = '0;
        res_vld    = 1'b1;
        res_eof    = 1'b1;
        res_status = (rx_byte == end_mark_q) ? lpfd_pkg::StOk : lpfd_pkg::StTerm;
      end
      default: begin
        if (rx_byte != exp_ver_q) begin
          phase_d    = PhVersion;
          res_vld    = 1'b1;
          res_type   = '0;
          res_len    = '0;
          res_status = lpfd_pkg::StVersion;
          res_eof    = 1'b1;
        end else begin
          phase_d = PhType;
        end
      end
    endcase
  end

  assign res_len_sat = (res_len > lpfd_pkg::LenW'(lpfd_pkg::LenOutMax))
                       ? lpfd_pkg::LenOutMax : res_len[lpfd_pkg::LenOutW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhVersion;
      type_q       <= '0;
      len_q        <= '0;
      cnt_q        <= '0;
      exp_ver_q    <= lpfd_pkg::ExpectedVersionReset;
      end_mark_q   <= lpfd_pkg::EndMarkerReset;
      out_vld_q    <= 1'b0;
      out_type_q   <= '0;
      out_data_q   <= '0;
      out_len_q    <= '0;
      out_status_q <= '0;
      out_eof_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lpfd_pkg::RegExpectedVersion: exp_ver_q  <= cfg_data_i;
          lpfd_pkg::RegEndMarker:       end_mark_q <= cfg_data_i;
          default:                      ;
        endcase
      end
      if (in_acc) begin
        phase_q <= phase_d;
        type_q  <= type_d;
        len_q   <= len_d;
        cnt_q   <= cnt_d;
      end
      if (s_axis_tready) begin
        out_vld_q <= in_acc && res_vld;
      end
      if (in_acc && res_vld) begin
        out_type_q   <= res_type;
        out_data_q   <= res_data;
        out_len_q    <= res_len_sat;
        out_status_q <= res_status;
        out_eof_q    <= res_eof;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, out_len_q, out_data_q, out_type_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_eof_q;

`ifndef SYNTHESIS
  a_payload_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPayload |-> (len_q != '0 && lpfd_pkg::LenW'(cnt_q) < len_q))
    else $error("payload phase with an exhausted length");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != lpfd_pkg::StOk) |-> m_axis_tlast)
    else $error("error status on a result that does not close the frame");

  a_payload_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPayload || phase_q == PhTerm) |-> len_q <= lpfd_pkg::LenW'(LENGTH_LIMIT))
    else $error("accepted frame length exceeds the limit");

  a_no_result_mid_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (phase_q == PhType || phase_q == PhLenHi)) |=> !m_axis_tvalid)
    else $error("result produced by a header byte");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Testbench for the length-prefixed frame deframer: scoreboard class, stream drivers and top.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned ItemsPerPhase = 60;
  localparam int unsigned LongHoldCycles = 80;

  typedef enum logic [2:0] {
    PhVersion, PhType, PhLenHi, PhLenLo, PhPayload, PhTerm
  } parse_phase_e;

  typedef struct packed {
    logic [lpfd_pkg::ByteW-1:0]   ftype;
    logic [lpfd_pkg::ByteW-1:0]   data;
    logic [lpfd_pkg::LenOutW-1:0] len;
    logic [lpfd_pkg::StatusW-1:0] status;
    logic                         eof;
  } frame_result_t;

  class deframe_scoreboard;
    logic [lpfd_pkg::ByteW-1:0] version_reg;
    logic [lpfd_pkg::ByteW-1:0] marker_reg;
    parse_phase_e               phase;
    logic [lpfd_pkg::ByteW-1:0] cur_type;
    logic [lpfd_pkg::LenW-1:0]  cur_len;
    int unsigned                seen;
    frame_result_t              due_results[$];
    int unsigned                errors;
    int unsigned                bytes_in;
    int unsigned                results_out;
    int unsigned                closed_ok;
    int unsigned                closed_bad;
    int unsigned                header_errors;

    function new();
      version_reg = lpfd_pkg::ExpectedVersionReset;
      marker_reg = lpfd_pkg::EndMarkerReset;
      phase = PhVersion;
      cur_type = '0;
      cur_len = '0;
      seen = 0;
      errors = 0;
      bytes_in = 0;
      results_out = 0;
      closed_ok = 0;
      closed_bad = 0;
      header_errors = 0;
    endfunction

    function void set_reg(logic [lpfd_pkg::CfgIdxW-1:0] idx, logic [lpfd_pkg::ByteW-1:0] val);
      if (idx == lpfd_pkg::RegExpectedVersion) version_reg = val;
      else if (idx == lpfd_pkg::RegEndMarker) marker_reg = val;
    endfunction

    function void push_result(logic [lpfd_pkg::ByteW-1:0] ftype,
                              logic [lpfd_pkg::ByteW-1:0] data,
                              logic [lpfd_pkg::LenW-1:0] len,
                              logic [lpfd_pkg::StatusW-1:0] status,
                              logic eof);
      frame_result_t r;
      r.ftype = ftype;
      r.data = data;
      r.len = (len > lpfd_pkg::LenW'(lpfd_pkg::LenOutMax))
              ? lpfd_pkg::LenOutMax : len[lpfd_pkg::LenOutW-1:0];
      r.status = status;
      r.eof = eof;
      due_results.push_back(r);
    endfunction

    function void absorb_byte(logic [lpfd_pkg::ByteW-1:0] b);
      bytes_in++;
      case (phase)
        PhType: begin
          cur_type = b;
          phase = PhLenHi;
        end
        PhLenHi: begin
          cur_len = {b, 8'h00};
          phase = PhLenLo;
        end
        PhLenLo: begin
          cur_len[7:0] = b;
          seen = 0;
          if (cur_len > lpfd_pkg::LenW'(lpfd_pkg::LengthLimitDefault)) begin
            phase = PhVersion;
            push_result(cur_type, '0, cur_len, lpfd_pkg::StTooLong, 1'b1);
          end else begin
            phase = (cur_len == '0) ? PhTerm : PhPayload;
          end
        end
        PhPayload: begin
          seen++;
          if (seen >= cur_len) phase = PhTerm;
          push_result(cur_type, b, cur_len, lpfd_pkg::StOk, 1'b0);
        end
        PhTerm: begin
          phase = PhVersion;
          seen = 0;
          push_result(cur_type, '0, cur_len,
                      (b == marker_reg) ? lpfd_pkg::StOk : lpfd_pkg::StTerm, 1'b1);
        end
        default: begin
          phase = PhVersion;
          if (b != version_reg) push_result('0, '0, '0, lpfd_pkg::StVersion, 1'b1);
          else phase = PhType;
        end
      endcase
    endfunction

    function void check_result(logic [lpfd_pkg::OutTdataW-1:0] tdata,
                               logic [lpfd_pkg::StatusW-1:0] tuser,
                               logic tlast);
      frame_result_t e;
      results_out++;
      if (due_results.size() == 0) begin
        $error("unexpected result: tdata %h tuser %0d tlast %0d", tdata, tuser, tlast);
        errors++;
        return;
      end
      e = due_results.pop_front();
      if (tdata[7:0] !== e.ftype) begin
        $error("frame_type: expected %0d, actual %0d", e.ftype, tdata[7:0]);
        errors++;
      end
      if (tdata[15:8] !== e.data) begin
        $error("data_byte: expected %0d, actual %0d", e.data, tdata[15:8]);
        errors++;
      end
      if (tdata[26:16] !== e.len) begin
        $error("payload_length: expected %0d, actual %0d", e.len, tdata[26:16]);
        errors++;
      end
      if (tdata[31:27] !== 5'd0) begin
        $error("tdata padding: expected 0, actual %0d", tdata[31:27]);
        errors++;
      end
      if (tuser !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, tuser);
        errors++;
      end
      if (tlast !== e.eof) begin
        $error("end_of_frame: expected %0d, actual %0d", e.eof, tlast);
        errors++;
      end
      if (e.eof) begin
        if (e.status == lpfd_pkg::StOk) closed_ok++;
        else if (e.status == lpfd_pkg::StTerm) closed_bad++;
        else header_errors++;
      end
    endfunction
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [lpfd_pkg::CfgIdxW-1:0]     cfg_idx_i = '0;
  logic [lpfd_pkg::ByteW-1:0]       cfg_data_i = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [lpfd_pkg::InTdataW-1:0]    s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [lpfd_pkg::OutTdataW-1:0]   m_axis_tdata;
  logic [lpfd_pkg::StatusW-1:0]     m_axis_tuser;
  logic                             m_axis_tlast;

  int unsigned            send_idle_pct = 0;
  int unsigned            recv_stall_pct = 0;
  logic                   long_hold_req = 1'b0;
  int unsigned            hold_left = 0;
  int unsigned            cycles = 0;
  int unsigned            phase_items = 0;
  deframe_scoreboard      sb = new();

  length_prefixed_frame_deframer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** length_prefixed_frame_deframer: FAILED **");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (long_hold_req) begin
      hold_left = LongHoldCycles;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  task automatic send_byte(input logic [lpfd_pkg::ByteW-1:0] b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.absorb_byte(b);
    phase_items++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (sb.due_results.size() > 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [lpfd_pkg::CfgIdxW-1:0] idx,
                           input logic [lpfd_pkg::ByteW-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic send_frame(input logic [lpfd_pkg::ByteW-1:0] ftype,
                            input logic [lpfd_pkg::LenW-1:0] len,
                            input logic [lpfd_pkg::ByteW-1:0] term);
    send_byte(sb.version_reg);
    send_byte(ftype);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    if (len <= lpfd_pkg::LenW'(lpfd_pkg::LengthLimitDefault)) begin
      for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom));
      send_byte(term);
    end
  endtask

  task automatic send_random_item();
    int unsigned pick;
    int unsigned len;
    logic [lpfd_pkg::ByteW-1:0] term;
    pick = $urandom_range(99);
    if (pick < 70) begin
      len = $urandom_range(99);
      if (len < 85) len = $urandom_range(8);
      else if (len < 98) len = $urandom_range(64, 9);
      else len = $urandom_range(200, 65);
      term = ($urandom_range(99) < 85) ? sb.marker_reg : 8'($urandom);
      send_frame(8'($urandom), lpfd_pkg::LenW'(len), term);
    end else if (pick < 80) begin
      send_frame(8'($urandom),
                 lpfd_pkg::LenW'($urandom_range(65535, lpfd_pkg::LengthLimitDefault + 1)),
                 '0);
    end else if (pick < 90) begin
      send_byte(8'($urandom));
    end else begin
      send_byte(sb.version_reg);
      len = $urandom_range(2);
      for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom));
    end
  endtask

  initial begin
    logic [lpfd_pkg::ByteW-1:0] settings[4][2];
    settings[0][0] = lpfd_pkg::ExpectedVersionReset;
    settings[0][1] = lpfd_pkg::EndMarkerReset;
    settings[1][0] = 8'd0;
    settings[1][1] = 8'd255;
    settings[2][0] = 8'd255;
    settings[2][1] = 8'd0;
    settings[3][0] = 8'($urandom);
    settings[3][1] = 8'($urandom);

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Zero-length frame, bad versions, oversize lengths and a bad terminator.
    send_frame(8'hFF, 16'd0, 8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'h00, 16'd1025, 8'h00);
    send_frame(8'h5A, 16'hFFFF, 8'h00);
    send_frame(8'hA5, 16'd2, 8'h7E);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      if (p > 0) begin
        write_reg(lpfd_pkg::RegExpectedVersion, settings[p][0]);
        write_reg(lpfd_pkg::RegEndMarker, settings[p][1]);
      end
      case (p)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 53;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 53;
        end
        default: begin
          send_idle_pct = 15;
          recv_stall_pct = 15;
        end
      endcase
      phase_items = 0;
      if (p == 0) begin
        long_hold_req = 1'b1;
        send_frame(8'($urandom), 16'd20, sb.marker_reg);
        send_frame(8'($urandom), lpfd_pkg::LenW'(lpfd_pkg::LengthLimitDefault), sb.marker_reg);
        phase_items = 0;
      end
      while (phase_items < ItemsPerPhase / 2) send_random_item();
      wait_drained();
      while (phase_items < ItemsPerPhase) send_random_item();
      wait_drained();
    end

    $display("Summary: %0d bytes in, %0d results checked over four register settings.",
             sb.bytes_in, sb.results_out);
    $display("Frames closed good %0d, bad terminator %0d, header errors %0d.",
             sb.closed_ok, sb.closed_bad, sb.header_errors);
    if (sb.errors == 0) begin
      $display("** length_prefixed_frame_deframer: PASSED **");
    end else begin
      $display("** length_prefixed_frame_deframer: FAILED **");
    end
    $finish;
  end
endmodule
